@@ hw/rtl/egcd_pkg.sv @@
// shared types and constants for the extended gcd inverse solver
`default_nettype none
package egcd_pkg;

	localparam int OPERAND_WIDTH = 30;
	localparam int CNT_W = $clog2(OPERAND_WIDTH);
	// signed coefficient width: holds [-m, m] with margin
	localparam int COEF_W = OPERAND_WIDTH + 2;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_CHECK  = 5'b00010,
		ST_DIV    = 5'b00100,
		ST_UPDATE = 5'b01000,
		ST_FINAL  = 5'b10000
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic div_init;
		logic div_step;
		logic update;
		logic finish;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic rb_zero;
		logic div_last;
	} sts_t;

endpackage
`default_nettype wire

@@ hw/rtl/egcd_ctrl.sv @@
// controller state machine sequencing the euclid steps
`default_nettype none
module egcd_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	output logic               done,
	output egcd_pkg::cmd_t     cmd,
	input  wire egcd_pkg::sts_t sts
);

	egcd_pkg::state_t state_q, state_d;
	logic done_q;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			egcd_pkg::ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = egcd_pkg::ST_CHECK;
				end
			end
			egcd_pkg::ST_CHECK: begin
				if (sts.rb_zero) begin
					state_d = egcd_pkg::ST_FINAL;
				end else begin
					cmd.div_init = 1'b1;
					state_d      = egcd_pkg::ST_DIV;
				end
			end
			egcd_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = egcd_pkg::ST_UPDATE;
				end
			end
			egcd_pkg::ST_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = egcd_pkg::ST_CHECK;
			end
			egcd_pkg::ST_FINAL: begin
				cmd.finish = 1'b1;
				state_d    = egcd_pkg::ST_IDLE;
			end
			default: begin
				state_d = egcd_pkg::ST_IDLE;
			end
		endcase
	end

	// state and result strobe registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= egcd_pkg::ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.finish;
		end
	end

	assign busy = (state_q != egcd_pkg::ST_IDLE);
	assign done = done_q;

endmodule
`default_nettype wire

@@ hw/rtl/egcd_dp.sv @@
// datapath: remainders, coefficients, bit-serial divider and final fixup
`default_nettype none
module egcd_dp (
	input  wire logic                                  clk,
	input  wire logic [egcd_pkg::OPERAND_WIDTH-1:0]    modulus_m,
	input  wire logic [egcd_pkg::OPERAND_WIDTH-1:0]    operand_n,
	input  wire egcd_pkg::cmd_t                        cmd,
	output egcd_pkg::sts_t                             sts,
	output logic                                       solvable,
	output logic [egcd_pkg::OPERAND_WIDTH-1:0]         least_y
);

	localparam int W  = egcd_pkg::OPERAND_WIDTH;
	localparam int CW = egcd_pkg::COEF_W;

	logic [W-1:0]               m_q, ra_q, rb_q, rem_q, dvd_q;
	logic [CW-1:0]              ta_q, tb_q, prod_q;
	logic [egcd_pkg::CNT_W-1:0] cnt_q;
	logic                       solvable_q;
	logic [W-1:0]               least_y_q;

	logic [W:0]    trial;
	logic          ge;
	logic [W:0]    trial_sub;
	logic [CW-1:0] prod_next;
	logic          neg;
	logic [CW-1:0] mag_raw;
	logic [W-1:0]  mag;
	logic [W-1:0]  y_val;
	logic          gcd_one;

	// one restoring division step, quotient bit folded into q*tb
	always_comb begin
		trial     = {rem_q, dvd_q[W-1]};
		trial_sub = trial - {1'b0, rb_q};
		ge        = (trial >= {1'b0, rb_q});
		prod_next = {prod_q[CW-2:0], 1'b0} + (ge ? tb_q : '0);
	end

	// final reduction of the coefficient of n into [0, m)
	always_comb begin
		neg     = ta_q[CW-1];
		mag_raw = neg ? (CW'(0) - ta_q) : ta_q;
		mag     = (mag_raw == {2'b00, m_q}) ? '0 : mag_raw[W-1:0];
		if (neg) begin
			y_val = mag;
		end else begin
			y_val = (mag == '0) ? '0 : (m_q - mag);
		end
		gcd_one = (ra_q == W'(1)) && (m_q != '0);
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			m_q  <= modulus_m;
			ra_q <= modulus_m;
			rb_q <= operand_n;
			ta_q <= '0;
			tb_q <= CW'(1);
		end
		if (cmd.div_init) begin
			rem_q  <= '0;
			dvd_q  <= ra_q;
			prod_q <= '0;
			cnt_q  <= '0;
		end
		if (cmd.div_step) begin
			rem_q  <= ge ? trial_sub[W-1:0] : trial[W-1:0];
			dvd_q  <= {dvd_q[W-2:0], 1'b0};
			prod_q <= prod_next;
			cnt_q  <= cnt_q + 1'b1;
		end
		if (cmd.update) begin
			ra_q <= rb_q;
			rb_q <= rem_q;
			ta_q <= tb_q;
			tb_q <= ta_q - prod_q;
		end
		if (cmd.finish) begin
			solvable_q <= gcd_one;
			least_y_q  <= gcd_one ? y_val : '0;
		end
	end

	assign sts.rb_zero  = (rb_q == '0);
	assign sts.div_last = (cnt_q == egcd_pkg::CNT_W'(W - 1));
	assign solvable     = solvable_q;
	assign least_y      = least_y_q;

endmodule
`default_nettype wire

@@ hw/rtl/extended_gcd_inverse_solver_unit.sv @@
// top level of the extended gcd negated-inverse solver
//
// usage: drive modulus_m and operand_n and raise start; the operands are
// taken at a rising edge where start is high and busy is low. busy stays
// high while the euclid iteration runs. when done pulses for one cycle,
// solvable and least_y hold the result: least_y is the smallest y in [0, m)
// with n*y = -1 mod m, or 0 when gcd(m, n) is not 1 or m is 0.
// each euclid step runs a check, the restoring divider (one quotient bit per
// cycle, OPERAND_WIDTH bits in all) and a coefficient update; after the last
// check come the final fixup and the done cycle.
// one item is in flight at a time; the next start can be taken in the cycle
// where done is high.
// reset clears the controller to idle with no strobe pending. the receiver
// cannot stall: each result must be captured in its done cycle.
`default_nettype none
module extended_gcd_inverse_solver_unit (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	output logic                                    busy,
	input  wire logic [egcd_pkg::OPERAND_WIDTH-1:0] modulus_m,
	input  wire logic [egcd_pkg::OPERAND_WIDTH-1:0] operand_n,
	output logic                                    done,
	output logic                                    solvable,
	output logic [egcd_pkg::OPERAND_WIDTH-1:0]      least_y
);

	egcd_pkg::cmd_t cmd;
	egcd_pkg::sts_t sts;

	// sequencing
	egcd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.sts    (sts)
	);

	// arithmetic
	egcd_dp u_dp (
		.clk       (clk),
		.modulus_m (modulus_m),
		.operand_n (operand_n),
		.cmd       (cmd),
		.sts       (sts),
		.solvable  (solvable),
		.least_y   (least_y)
	);

endmodule
`default_nettype wire
